FILE: hw/rtl/urt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urt_pkg
// Shared types and constants of the 8N1 UART transceiver with receive FIFO.
// ----------------------------------------------------------------------------
package urt_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;

  localparam logic [15:0] BIT_TIME_RST = 16'd104;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd1;

  localparam logic [3:0] DATA_BITS = 4'd8;
  localparam logic [3:0] STOP_IDX  = 4'd9;
  localparam logic [3:0] FRAME_END = 4'd10;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_PEEK  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [15:0] period;
    logic        enable;
  } cfg_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       rx_level;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [5:0] count;
  } rd_res_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic accepted;
  } tx_res_t;

endpackage

FILE: hw/rtl/urt_rx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urt_rx
// Receive sampler: start edge detection, mid-bit sampling, byte push request.
// ----------------------------------------------------------------------------
module urt_rx (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  urt_pkg::cfg_t cfg_i,
  input  logic          level_i,
  output urt_pkg::push_t push_o
);
  import urt_pkg::*;

  logic        prev_q, prev_d;
  logic        active_q, active_d;
  logic [16:0] timer_q, timer_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [16:0] dec;

  always_comb begin
    prev_d      = level_i;
    active_d    = active_q;
    timer_d     = timer_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    push_o      = '0;
    push_o.data = shift_q;
    dec         = timer_q - 17'd1;
    if (active_q) begin
      timer_d = dec;
      if (dec == '0) begin
        if (idx_q < DATA_BITS) begin
          shift_d = shift_q | (8'(level_i) << idx_q[2:0]);
          idx_d   = idx_q + 4'd1;
          timer_d = {1'b0, cfg_i.period};
        end else begin
          push_o.valid = 1'b1;
          active_d     = 1'b0;
        end
      end
    end else if (cfg_i.enable && prev_q && !level_i) begin
      active_d = 1'b1;
      timer_d  = {1'b0, cfg_i.period} + {2'b0, cfg_i.period[15:1]};
      idx_d    = '0;
      shift_d  = '0;
    end
    if (!step_i) begin
      push_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b1;
      active_q <= 1'b0;
      timer_q  <= '0;
      idx_q    <= '0;
      shift_q  <= '0;
    end else if (step_i) begin
      prev_q   <= prev_d;
      active_q <= active_d;
      timer_q  <= timer_d;
      idx_q    <= idx_d;
      shift_q  <= shift_d;
    end
  end

endmodule

FILE: hw/rtl/urt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urt_fifo
// Receive ring buffer with a prefetched head word and same-beat push bypass.
// ----------------------------------------------------------------------------
module urt_fifo #(
  parameter int unsigned FIFO_DEPTH = urt_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  urt_pkg::push_t  push_i,
  input  urt_pkg::cmd_e   cmd_i,
  output urt_pkg::rd_res_t res_o
);
  import urt_pkg::*;

  localparam int unsigned PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = (PW + 1 > 6) ? PW + 1 : 6;

  logic [7:0]    mem [FIFO_DEPTH];
  logic [7:0]    rdata_q;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PW-1:0] tail_nx, head_nx;
  logic          empty, push_ok, wr_en, is_rd;
  logic [PW:0]   diff, diff_fix;
  logic [CNT_W-1:0] cnt_w;

  always_comb begin
    tail_nx = (tail_q == PW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
    head_nx = (head_q == PW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
    empty   = (head_q == tail_q);
    push_ok = push_i.valid && (tail_nx != head_q);
    wr_en   = step_i && push_ok;
    is_rd   = (cmd_i == CMD_READ) || (cmd_i == CMD_PEEK);
    tail_d  = push_ok ? tail_nx : tail_q;
    head_d  = head_q;
    res_o   = '0;
    if (is_rd && (!empty || push_ok)) begin
      res_o.valid = 1'b1;
      res_o.data  = empty ? push_i.data : rdata_q;
      if (cmd_i == CMD_READ) begin
        head_d = head_nx;
      end
    end
    if (!step_i) begin
      head_d = head_q;
      tail_d = tail_q;
    end
    diff     = {1'b0, tail_d} - {1'b0, head_d};
    diff_fix = diff[PW] ? diff + (PW + 1)'(FIFO_DEPTH) : diff;
    cnt_w    = CNT_W'(diff_fix);
    res_o.count = cnt_w[5:0];
  end

  // head word prefetch, bypassing a write to the slot about to be read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= push_i.data;
    end
    if (wr_en && (tail_q == head_d)) begin
      rdata_q <= push_i.data;
    end else begin
      rdata_q <= mem[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

FILE: hw/rtl/urt_tx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urt_tx
// Transmit shifter: start bit, eight data bits LSB first, stop bit.
// ----------------------------------------------------------------------------
module urt_tx (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  urt_pkg::cfg_t    cfg_i,
  input  urt_pkg::cmd_e    cmd_i,
  input  logic [7:0]       byte_i,
  output urt_pkg::tx_res_t res_o
);
  import urt_pkg::*;

  logic        active_q, active_d;
  logic [15:0] timer_q, timer_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] dec;
  logic [3:0]  idx_inc;
  logic [3:0]  bit_sel;

  always_comb begin
    active_d = active_q;
    timer_d  = timer_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    res_o    = '0;
    dec      = timer_q - 16'd1;
    idx_inc  = idx_q + 4'd1;
    if (active_q) begin
      timer_d = dec;
      if (dec == '0) begin
        if (idx_inc >= FRAME_END) begin
          active_d = 1'b0;
          idx_d    = '0;
        end else begin
          idx_d   = idx_inc;
          timer_d = cfg_i.period;
        end
      end
    end
    if ((cmd_i == CMD_WRITE) && cfg_i.enable && !active_d) begin
      active_d       = 1'b1;
      idx_d          = '0;
      shift_d        = byte_i;
      timer_d        = cfg_i.period;
      res_o.accepted = 1'b1;
    end
    bit_sel    = idx_d - 4'd1;
    res_o.busy = active_d;
    if (!active_d || (idx_d >= STOP_IDX)) begin
      res_o.level = 1'b1;
    end else if (idx_d == '0) begin
      res_o.level = 1'b0;
    end else begin
      res_o.level = shift_d[bit_sel[2:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      timer_q  <= '0;
      idx_q    <= '0;
      shift_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      timer_q  <= timer_d;
      idx_q    <= idx_d;
      shift_q  <= shift_d;
    end
  end

endmodule

FILE: hw/rtl/uart_8n1_rx_fifo_tx_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_rx_fifo_tx_unit
// 8N1 UART transceiver with receive FIFO, one tick beat in, one result out.
//
//   channel  dir  fields (lsb first)
//   s_axis   in   command[1:0] tx_byte[9:2] rx_level[10]
//   m_axis   out  tx_level tx_busy write_accepted read_valid read_data rx_count
//   cfg      in   cfg_index_i (0 bit time, 1 enable), cfg_data_i
//
// one beat per clock sustained while the output is not stalled; the result of a
// beat is computed between the input register and the result register.
// the receive buffer head word is prefetched from its memory every cycle.
// an output stall holds the input register; no clearing pass after reset.
// ----------------------------------------------------------------------------
module uart_8n1_rx_fifo_tx_unit #(
  parameter int unsigned FIFO_DEPTH = urt_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // command[1:0], tx_byte[9:2], rx_level[10], zero fill
  input  logic [urt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tx_level[0], tx_busy[1], write_accepted[2], read_valid[3],
  // read_data[11:4], rx_count[17:12], zero fill
  output logic [urt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [urt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import urt_pkg::*;

  logic [15:0] bit_time_q;
  logic        enable_q;
  cfg_t        cfg;
  logic        in_v_q, out_v_q, step;
  item_t       in_q;
  push_t       push;
  rd_res_t     rd_res;
  tx_res_t     tx_res;
  logic [OUT_DATA_W-1:0] out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign cfg.period  = (bit_time_q == '0) ? 16'd1 : bit_time_q;
  assign cfg.enable  = enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q <= BIT_TIME_RST;
      enable_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BIT_TIME: bit_time_q <= cfg_data_i;
        REG_ENABLE:   enable_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign step          = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.cmd      <= cmd_e'(s_axis_tdata[1:0]);
      in_q.tx_byte  <= s_axis_tdata[9:2];
      in_q.rx_level <= s_axis_tdata[10];
    end
  end

  urt_rx u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cfg_i   (cfg),
    .level_i (in_q.rx_level),
    .push_o  (push)
  );

  urt_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .push_i (push),
    .cmd_i  (in_q.cmd),
    .res_o  (rd_res)
  );

  urt_tx u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .cmd_i  (in_q.cmd),
    .byte_i (in_q.tx_byte),
    .res_o  (tx_res)
  );

  assign out_d = {6'b0, rd_res.count, rd_res.data, rd_res.valid,
                  tx_res.accepted, tx_res.busy, tx_res.level};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: hw/rtl/urt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urt_checker
// Port-level checks on the result stream of the UART transceiver.
// ----------------------------------------------------------------------------
module urt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [urt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import urt_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // an accepted write puts the start bit on the line at once
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1] && !m_axis_tdata[0])
    else $error("accepted write without start bit");

  // idle line stays high
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("line low while transmitter idle");

  // no byte means zero data
  a_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[11:4] == 8'd0)
    else $error("read data nonzero without valid byte");

endmodule

bind uart_8n1_rx_fifo_tx_unit urt_checker u_urt_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8N1 UART transceiver with receive FIFO.
// A queue of tick beats feeds a stream driver. Every beat taken by the block
// runs through a tick-accurate model of the receive sampler, the ring buffer
// and the transmitter. Each output beat is checked field by field against the
// oldest prediction. Both stream sides idle at random, with calm stretches.
// Register writes fall between phases, some of them mid-frame, and cover
// the zero and the full-range bit time.
// ----------------------------------------------------------------------------
module tb_top;
  import urt_pkg::*;

  localparam int unsigned DEPTH       = FIFO_DEPTH_DEF;
  localparam int unsigned PTR_W       = $clog2(DEPTH);
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic       tx_level;
    logic       tx_busy;
    logic       wr_ok;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic [5:0] count;
  } tick_res_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  item_t     tick_q[$];
  tick_res_t tick_res_q[$];

  // model copy of registers and line state
  logic [15:0] bit_time    = BIT_TIME_RST;
  logic        en          = 1'b0;
  logic        rx_last_lvl = 1'b1;
  logic        rx_run      = 1'b0;
  logic [16:0] rx_cnt      = '0;
  logic [3:0]  rx_bit      = '0;
  logic [7:0]  rx_word     = '0;
  logic [7:0]  fifo_mem [DEPTH];
  int unsigned rd_ptr      = 0;
  int unsigned wr_ptr      = 0;
  logic        tx_run      = 1'b0;
  logic [15:0] tx_cnt      = '0;
  logic [3:0]  tx_bit      = '0;
  logic [7:0]  tx_word     = '0;

  int unsigned cyc = 0, quiet = 0, n_queued = 0, n_cfg = 0, n_chk = 0, n_err = 0;
  int unsigned n_rx_bytes = 0, n_dropped = 0, n_read_back = 0, n_tx_frames = 0;
  logic        in_taken = 1'b0;
  wire         calm = (cyc % 2500) < 400;

  uart_8n1_rx_fifo_tx_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic tick_res_t predict_tick(item_t it);
    tick_res_t   r;
    logic [16:0] per;
    int unsigned nxt;
    int unsigned fill;
    per = (bit_time == 16'd0) ? 17'd1 : {1'b0, bit_time};
    r = '0;
    if (rx_run) begin
      rx_cnt = rx_cnt - 17'd1;
      if (rx_cnt == 17'd0) begin
        if (rx_bit < DATA_BITS) begin
          rx_word[rx_bit[2:0]] = it.rx_level;
          rx_bit = rx_bit + 4'd1;
          rx_cnt = per;
        end else begin
          nxt = (wr_ptr + 1) % DEPTH;
          if (nxt != rd_ptr) begin
            fifo_mem[wr_ptr[PTR_W-1:0]] = rx_word;
            wr_ptr = nxt;
            n_rx_bytes++;
          end else begin
            n_dropped++;
          end
          rx_run = 1'b0;
        end
      end
    end else if (en && rx_last_lvl && !it.rx_level) begin
      rx_run  = 1'b1;
      rx_cnt  = per + (per >> 1);
      rx_bit  = '0;
      rx_word = '0;
    end
    rx_last_lvl = it.rx_level;

    if ((it.cmd == CMD_READ || it.cmd == CMD_PEEK) && rd_ptr != wr_ptr) begin
      r.rd_valid = 1'b1;
      r.rd_data  = fifo_mem[rd_ptr[PTR_W-1:0]];
      if (it.cmd == CMD_READ) begin
        rd_ptr = (rd_ptr + 1) % DEPTH;
        n_read_back++;
      end
    end

    if (tx_run) begin
      tx_cnt = tx_cnt - 16'd1;
      if (tx_cnt == 16'd0) begin
        tx_bit = tx_bit + 4'd1;
        if (tx_bit >= FRAME_END) begin
          tx_run = 1'b0;
          tx_bit = '0;
        end else begin
          tx_cnt = per[15:0];
        end
      end
    end

    if (it.cmd == CMD_WRITE && en && !tx_run) begin
      tx_run  = 1'b1;
      tx_bit  = '0;
      tx_word = it.tx_byte;
      tx_cnt  = per[15:0];
      r.wr_ok = 1'b1;
      n_tx_frames++;
    end

    if (!tx_run || tx_bit >= STOP_IDX) begin
      r.tx_level = 1'b1;
    end else if (tx_bit == 4'd0) begin
      r.tx_level = 1'b0;
    end else begin
      r.tx_level = tx_word[3'(tx_bit - 4'd1)];
    end
    r.tx_busy = tx_run;
    fill = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    r.count = fill[5:0];
    return r;
  endfunction

  // stream driver, changes on the falling edge
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, tick_q[0].rx_level, tick_q[0].tx_byte, tick_q[0].cmd};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= calm || $urandom_range(99) >= 20;
  end

  // monitor and checker on the rising edge
  always @(posedge clk_i) begin : mon
    item_t     it;
    tick_res_t exp_r;
    logic      in_fire, out_fire;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    cyc      <= cyc + 1;
    in_taken <= in_fire;
    if (in_fire || out_fire || (rst_ni && cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (out_fire) begin
      if (tick_res_q.size() == 0) begin
        if (n_err < 10) begin
          $display("%0t: result beat %h with nothing expected", $time, m_axis_tdata);
        end
        n_err++;
      end else begin
        exp_r = tick_res_q.pop_front();
        n_chk++;
        if (m_axis_tdata[0] !== exp_r.tx_level || m_axis_tdata[1] !== exp_r.tx_busy ||
            m_axis_tdata[2] !== exp_r.wr_ok || m_axis_tdata[3] !== exp_r.rd_valid ||
            m_axis_tdata[11:4] !== exp_r.rd_data || m_axis_tdata[17:12] !== exp_r.count) begin
          if (n_err < 10) begin
            $display("%0t: result %0d exp lvl %b busy %b wr %b rv %b data %h cnt %0d",
                     $time, n_chk, exp_r.tx_level, exp_r.tx_busy, exp_r.wr_ok,
                     exp_r.rd_valid, exp_r.rd_data, exp_r.count);
            $display("%0t: result %0d got lvl %b busy %b wr %b rv %b data %h cnt %0d",
                     $time, n_chk, m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2],
                     m_axis_tdata[3], m_axis_tdata[11:4], m_axis_tdata[17:12]);
          end
          n_err++;
        end
      end
    end
    if (in_fire) begin
      it = tick_q.pop_front();
      tick_res_q.push_back(predict_tick(it));
    end
  end

  function automatic void add_tick(cmd_e cmd, logic [7:0] byt, logic lvl);
    item_t it;
    it.cmd      = cmd;
    it.tx_byte  = byt;
    it.rx_level = lvl;
    tick_q.push_back(it);
    n_queued++;
  endfunction

  function automatic cmd_e pick_cmd(int unsigned rd_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < rd_pct) return CMD_READ;
    if (r < rd_pct + 6) return CMD_PEEK;
    if (r < rd_pct + 14) return CMD_WRITE;
    return CMD_TICK;
  endfunction

  // receive frames at the current bit time, noisy ones get glitches and cut frames
  task automatic queue_frames(int unsigned n, int unsigned rd_pct, bit noisy);
    int unsigned bt;
    int unsigned nbits;
    int unsigned b;
    logic [7:0]  d;
    logic        lv;
    bt = {16'd0, bit_time};
    if (bt == 0) bt = 1;
    repeat (n) begin
      d = 8'($urandom);
      nbits = (noisy && $urandom_range(3) == 0) ? $urandom_range(1, 9) : 10;
      for (b = 0; b < nbits; b++) begin
        lv = (b == 0) ? 1'b0 : (b == 9) ? 1'b1 : d[3'(b - 1)];
        repeat (bt) begin
          add_tick(pick_cmd(rd_pct), 8'($urandom),
                   (noisy && $urandom_range(19) == 0) ? ~lv : lv);
        end
      end
      repeat ($urandom_range(0, 2 * bt)) add_tick(pick_cmd(rd_pct), 8'($urandom), 1'b1);
    end
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || tick_res_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_BIT_TIME) begin
      bit_time = val;
    end else begin
      en = val[0];
    end
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [11:0] line_pat;
    int unsigned i;
    int unsigned seg;
    int unsigned rand_base;
    logic [15:0] bt_pick;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: disabled, reads on an empty buffer
    add_tick(CMD_READ, 8'h00, 1'b1);
    add_tick(CMD_PEEK, 8'hFF, 1'b1);
    add_tick(CMD_WRITE, 8'hFF, 1'b1);
    add_tick(CMD_TICK, 8'h00, 1'b0);
    add_tick(CMD_TICK, 8'hFF, 1'b1);
    wait_idle();

    // zero bit time runs as one tick; writes every tick hit busy and frame end
    write_reg(REG_BIT_TIME, 16'd0);
    write_reg(REG_ENABLE, 16'd1);
    line_pat = {3'b111, 8'h5A, 1'b0};
    for (i = 0; i < 12; i++) add_tick(CMD_WRITE, i[0] ? 8'hFF : 8'h00, line_pat[4'(i)]);
    add_tick(CMD_PEEK, 8'h00, 1'b1);
    add_tick(CMD_READ, 8'h00, 1'b1);
    add_tick(CMD_READ, 8'h00, 1'b1);
    add_tick(CMD_PEEK, 8'h00, 1'b1);
    wait_idle();

    // overfill the buffer, then drain it past empty
    queue_frames(70, 0, 1'b0);
    repeat (70) add_tick(CMD_READ, 8'($urandom), 1'b1);
    wait_idle();

    // full-range bit time on a quiet line, then shortened mid-frame on both directions
    write_reg(REG_BIT_TIME, 16'hFFFF);
    repeat (4) add_tick(CMD_PEEK, 8'h00, 1'b1);
    wait_idle();
    write_reg(REG_BIT_TIME, 16'd40);
    add_tick(CMD_TICK, 8'h00, 1'b1);
    add_tick(CMD_WRITE, 8'hC3, 1'b0);
    repeat (3) add_tick(pick_cmd(10), 8'($urandom), 1'b0);
    wait_idle();
    write_reg(REG_BIT_TIME, 16'd2);
    repeat (200) add_tick(pick_cmd(8), 8'($urandom), $urandom_range(3) != 0);
    wait_idle();

    // random phases, each ending with a write on a low line to start frames in both directions where enabled
    seg = 0;
    rand_base = n_queued;
    while (n_queued - rand_base < 1000) begin
      wait_idle();
      case ($urandom_range(7))
        0:       bt_pick = 16'd0;
        1, 2:    bt_pick = 16'd1;
        3:       bt_pick = 16'd2;
        4:       bt_pick = 16'd3;
        5:       bt_pick = 16'd4;
        6:       bt_pick = 16'd5;
        default: bt_pick = 16'($urandom_range(6, 10));
      endcase
      write_reg(REG_BIT_TIME, bt_pick);
      write_reg(REG_ENABLE, (seg % 5 == 1) ? 16'd0 : 16'd1);
      queue_frames($urandom_range(2, 5), $urandom_range(5, 30), $urandom_range(3) == 0);
      add_tick(CMD_WRITE, 8'($urandom), 1'b0);
      repeat ($urandom_range(0, 4)) add_tick(pick_cmd(15), 8'($urandom), 1'($urandom));
      seg++;
    end

    wait_idle();
    repeat (4) @(negedge clk_i);
    $display("ran %0d tick beats in %0d phases with %0d register writes, %0d results checked",
             n_queued, seg, n_cfg, n_chk);
    $display("rx stored %0d bytes, dropped %0d, %0d read back; tx started %0d frames",
             n_rx_bytes, n_dropped, n_read_back, n_tx_frames);
    if (n_err == 0) begin
      $display("uart_8n1_rx_fifo_tx_unit test passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("uart_8n1_rx_fifo_tx_unit test failed");
    end
    $finish;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("uart_8n1_rx_fifo_tx_unit test failed");
    $finish;
  end

endmodule
